// ===== src/tlpt_pkg.sv =====
// Shared constants and types of the two-level page table engine.
package tlpt_pkg;

  // Default geometry of a 32-bit virtual address
  localparam int unsigned DirIndexBits   = 10;
  localparam int unsigned TableIndexBits = 10;
  localparam int unsigned PageOffsetBits = 12;

  // Fixed field widths
  localparam int unsigned AddrBits = 32;
  localparam int unsigned AttrBits = 12;
  localparam int unsigned ModeBits = 3;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataBits  = 112;
  localparam int unsigned OutDataBits = 40;

  // Operation codes carried in the input tuser
  typedef enum logic [ModeBits-1:0] {
    ModeTranslate = 3'd0,
    ModeMap       = 3'd1,
    ModeUnmap     = 3'd2,
    ModeClear     = 3'd3,
    ModeSetDir    = 3'd4
  } mode_e;

endpackage

// ===== src/two_level_page_table_engine_core.sv =====
// Two-level page table engine: directory flags and page entries in on-chip memories.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tuser: mode; tdata: virt_addr, phys_addr, attr, dir_value
// m_axis    out  m_axis_tvalid/tready   tuser: ok; tdata: phys_result, table_present
//
// For an item, the transfer cycle issues the reads of the directory flag and
// the page entry; StExec then modifies and writes back through the port of the memory it changes.
// A table clear of a present table adds a sweep of its 2^TABLE_INDEX_BITS entries, one entry written a cycle.
// After reset a sweep over all 2^(DIR_INDEX_BITS+TABLE_INDEX_BITS) entries (1048576 by default)
// zeroes both memories; s_axis_tready stays low until it ends.
// A result waits in the output register; the next item is taken meanwhile, and its
// write-back holds until the output register is free.
module two_level_page_table_engine_core #(
  parameter int unsigned DIR_INDEX_BITS   = tlpt_pkg::DirIndexBits,
  parameter int unsigned TABLE_INDEX_BITS = tlpt_pkg::TableIndexBits,
  parameter int unsigned PAGE_OFFSET_BITS = tlpt_pkg::PageOffsetBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] virt_addr, [63:32] phys_addr, [75:64] attr, [107:76] dir_value, rest zero
  input  logic [tlpt_pkg::InDataBits-1:0]  s_axis_tdata,
  // [2:0] mode
  input  logic [tlpt_pkg::ModeBits-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] phys_result, [32] table_present, rest zero
  output logic [tlpt_pkg::OutDataBits-1:0] m_axis_tdata,
  // [0] ok
  output logic                             m_axis_tuser
);

  localparam int unsigned AddrBits  = tlpt_pkg::AddrBits;
  localparam int unsigned AttrBits  = tlpt_pkg::AttrBits;
  localparam int unsigned EntryBits = DIR_INDEX_BITS + TABLE_INDEX_BITS;
  localparam int unsigned DirDepth  = 1 << DIR_INDEX_BITS;
  localparam int unsigned PageDepth = 1 << EntryBits;
  localparam int unsigned DirLsb    = PAGE_OFFSET_BITS + TABLE_INDEX_BITS;
  localparam logic [AddrBits-1:0] OffsetMask =
    AddrBits'((64'd1 << PAGE_OFFSET_BITS) - 64'd1);
  localparam logic [AddrBits-1:0] FrameMask = ~OffsetMask;
  localparam logic [AddrBits-1:0] PresentBit = AddrBits'(1);

  typedef enum logic [1:0] {
    StInit,
    StIdle,
    StExec,
    StClear
  } state_e;

  state_e                state_q;
  logic [EntryBits-1:0]  walk_q;

  // Item held while it is worked on
  tlpt_pkg::mode_e       mode_q;
  logic [AddrBits-1:0]   va_q;
  logic [AddrBits-1:0]   pa_q;
  logic [AttrBits-1:0]   attr_q;
  logic [AddrBits-1:0]   dv_q;

  // Memories and their registered read data
  logic                  dir_mem  [0:DirDepth-1];
  logic [AddrBits-1:0]   page_mem [0:PageDepth-1];
  logic                  dir_rdata_q;
  logic [AddrBits-1:0]   page_rdata_q;

  logic                  dir_we;
  logic [DIR_INDEX_BITS-1:0] dir_waddr;
  logic                  dir_wdata;
  logic                  page_we;
  logic [EntryBits-1:0]  page_waddr;
  logic [AddrBits-1:0]   page_wdata;

  // Output register
  logic                  out_valid_q;
  logic                  out_ok_q;
  logic [AddrBits-1:0]   out_phys_q;
  logic                  out_tp_q;

  logic                  in_fire;
  logic                  out_free;
  logic [63:0]           in_va_wide;
  logic [DIR_INDEX_BITS-1:0]   in_dir;
  logic [EntryBits-1:0]  in_slot;
  logic [63:0]           va_wide;
  logic [DIR_INDEX_BITS-1:0]   dir_idx;
  logic [EntryBits-1:0]  slot_idx;
  logic                  present;
  logic                  res_ok;
  logic [AddrBits-1:0]   res_phys;
  logic                  res_tp;
  logic                  clear_start;
  logic                  clear_done;
  logic                  exec_go;
  logic                  emit;
  logic [AddrBits-1:0]   map_value;

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Split the incoming and the held virtual address; bits above the directory read as zero
  assign in_va_wide = {32'd0, s_axis_tdata[AddrBits-1:0]};
  assign in_dir     = in_va_wide[DirLsb +: DIR_INDEX_BITS];
  assign in_slot    = {in_dir, in_va_wide[PAGE_OFFSET_BITS +: TABLE_INDEX_BITS]};
  assign va_wide    = {32'd0, va_q};
  assign dir_idx    = va_wide[DirLsb +: DIR_INDEX_BITS];
  assign slot_idx   = {dir_idx, va_wide[PAGE_OFFSET_BITS +: TABLE_INDEX_BITS]};

  assign present   = dir_rdata_q;
  assign map_value = (pa_q & FrameMask)
                   | ({{(AddrBits-AttrBits){1'b0}}, attr_q} & OffsetMask)
                   | PresentBit;

  // Form the result from the entry and flag read for the held item
  always_comb begin
    res_ok   = 1'b0;
    res_phys = '0;
    res_tp   = present;
    unique case (mode_q)
      tlpt_pkg::ModeTranslate: begin
        if (present && (page_rdata_q != '0)) begin
          res_ok   = 1'b1;
          res_phys = (page_rdata_q & FrameMask) | (va_q & OffsetMask);
        end
      end
      tlpt_pkg::ModeMap:    res_ok = present && (page_rdata_q == '0);
      tlpt_pkg::ModeUnmap:  res_ok = present;
      tlpt_pkg::ModeClear:  res_ok = present;
      tlpt_pkg::ModeSetDir: begin
        res_ok = 1'b1;
        res_tp = (dv_q != '0);
      end
      default: ;
    endcase
  end

  assign clear_start = (state_q == StExec) && (mode_q == tlpt_pkg::ModeClear) && present;
  assign exec_go     = (state_q == StExec) && !clear_start && out_free;
  assign clear_done  = (state_q == StClear) && (walk_q[TABLE_INDEX_BITS-1:0] == '1);
  assign emit        = exec_go || (clear_done && out_free);

  // Select the write-back of each memory
  always_comb begin
    dir_we     = 1'b0;
    dir_waddr  = dir_idx;
    dir_wdata  = 1'b0;
    page_we    = 1'b0;
    page_waddr = slot_idx;
    page_wdata = '0;
    unique case (state_q)
      StInit: begin
        dir_we     = 1'b1;
        dir_waddr  = walk_q[DIR_INDEX_BITS-1:0];
        page_we    = 1'b1;
        page_waddr = walk_q;
      end
      StClear: begin
        page_we    = 1'b1;
        page_waddr = {dir_idx, walk_q[TABLE_INDEX_BITS-1:0]};
      end
      StExec: begin
        if (exec_go) begin
          if (mode_q == tlpt_pkg::ModeMap && res_ok) begin
            page_we    = 1'b1;
            page_wdata = map_value;
          end else if (mode_q == tlpt_pkg::ModeUnmap && res_ok) begin
            page_we    = 1'b1;
          end else if (mode_q == tlpt_pkg::ModeSetDir) begin
            dir_we     = 1'b1;
            dir_wdata  = res_tp;
          end
        end
      end
      default: ;
    endcase
  end

  // Directory flags: reads only at a transfer, writes never in that state
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (in_fire) begin
      dir_rdata_q <= dir_mem[in_dir];
    end
  end

  // Page entries
  always_ff @(posedge clk_i) begin
    if (page_we) begin
      page_mem[page_waddr] <= page_wdata;
    end
    if (in_fire) begin
      page_rdata_q <= page_mem[in_slot];
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= tlpt_pkg::mode_e'(s_axis_tuser);
      va_q   <= s_axis_tdata[31:0];
      pa_q   <= s_axis_tdata[63:32];
      attr_q <= s_axis_tdata[75:64];
      dv_q   <= s_axis_tdata[107:76];
    end
  end

  // Sequence the sweeps and items, and hold the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_phys_q  <= '0;
      out_tp_q    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        out_ok_q    <= res_ok;
        out_phys_q  <= res_phys;
        out_tp_q    <= res_tp;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StInit: begin
          walk_q <= walk_q + EntryBits'(1);
          if (walk_q == '1) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_fire) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          if (clear_start) begin
            state_q <= StClear;
            walk_q  <= '0;
          end else if (out_free) begin
            state_q <= StIdle;
          end
        end
        StClear: begin
          if (!clear_done) begin
            walk_q <= walk_q + EntryBits'(1);
          end else if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {{(tlpt_pkg::OutDataBits-AddrBits-1){1'b0}}, out_tp_q, out_phys_q};

endmodule
